// ----- design/ccsds_turbo_interleaver_address_defines.svh -----
// ----------------------------------------------------------------------------
// CCSDS turbo interleaver address - assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef CCSDS_TURBO_INTERLEAVER_ADDRESS_DEFINES_SVH
`define CCSDS_TURBO_INTERLEAVER_ADDRESS_DEFINES_SVH

// same-cycle implication, masked during reset
`define CTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccsds interleaver: same-cycle check failed");

// next-cycle implication, masked during reset
`define CTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccsds interleaver: next-cycle check failed");

`endif

// ----- design/ccsds_ti_pkg.sv -----
// ----------------------------------------------------------------------------
// CCSDS turbo interleaver address - package
// Widths, frame-size tables and the per-stage tag type.
// ----------------------------------------------------------------------------
package ccsds_ti_pkg;

    localparam int POS_W       = 14;
    localparam int SIZE_W      = 2;
    localparam int HALF_W      = POS_W - 1;
    localparam int K2_W        = 11;
    localparam int COL_W       = 11;
    localparam int PRIME_W     = 6;
    localparam int PROD_W      = 17;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 20;
    localparam int Q_W         = 6;
    localparam int REM_W       = K2_W + 1;

    localparam logic [POS_W-1:0] FRAME_LEN_MAX = POS_W'(8920);

    localparam logic [SIZE_W-1:0] SIZE_1784 = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_3568 = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_7136 = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_8920 = 2'd3;

    localparam logic [PROD_W-1:0] PARITY_OFFSET = PROD_W'(21);

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SIZE_W-1:0] size_t;

    // side information that travels with each request
    typedef struct packed {
        logic [1:0] t;
        logic       m;
        logic       oor;
    } tag_t;

    function automatic logic [K2_W-1:0] k2_of(input size_t sel);
        logic [K2_W-1:0] k2;
        case (sel)
            SIZE_1784: k2 = K2_W'(223);
            SIZE_3568: k2 = K2_W'(446);
            SIZE_7136: k2 = K2_W'(892);
            SIZE_8920: k2 = K2_W'(1115);
            default:   k2 = K2_W'(223);
        endcase
        return k2;
    endfunction

    // floor(2^RECIP_SHIFT / k2)
    function automatic logic [RECIP_W-1:0] recip_of(input size_t sel);
        logic [RECIP_W-1:0] r;
        case (sel)
            SIZE_1784: r = RECIP_W'(4702);
            SIZE_3568: r = RECIP_W'(2351);
            SIZE_7136: r = RECIP_W'(1175);
            SIZE_8920: r = RECIP_W'(940);
            default:   r = RECIP_W'(4702);
        endcase
        return r;
    endfunction

    // t = (19*row + 1) mod 4
    function automatic logic [1:0] t_of_row(input logic [1:0] row);
        logic [1:0] t;
        case (row)
            2'd0:    t = 2'd1;
            2'd1:    t = 2'd0;
            2'd2:    t = 2'd3;
            2'd3:    t = 2'd2;
            default: t = 2'd1;
        endcase
        return t;
    endfunction

    function automatic logic [PRIME_W-1:0] prime_of(input logic [1:0] t);
        logic [PRIME_W-1:0] p;
        case (t)
            2'd0:    p = PRIME_W'(31);
            2'd1:    p = PRIME_W'(37);
            2'd2:    p = PRIME_W'(43);
            2'd3:    p = PRIME_W'(47);
            default: p = PRIME_W'(31);
        endcase
        return p;
    endfunction

endpackage

// ----- design/ccsds_turbo_interleaver_address.sv -----
// ----------------------------------------------------------------------------
// CCSDS turbo interleaver address generator
// Pipeline stages from accepted request to out_valid: decompose, multiply,
// reciprocal multiply, subtract, reduce; throughput one request per cycle unless out_ready stalls it.
// Reset clears every stage valid bit and sets the frame size to 1784.
// ----------------------------------------------------------------------------
module ccsds_turbo_interleaver_address (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  ccsds_ti_pkg::size_t cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  ccsds_ti_pkg::pos_t  position,
    output logic                out_valid,
    input  logic                out_ready,
    output ccsds_ti_pkg::pos_t  permuted_position,
    output logic                out_of_range
);
    import ccsds_ti_pkg::*;

    size_t size_select_reg;

    logic [K2_W-1:0]    k2;
    logic [RECIP_W-1:0] recip;

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: split into row, column, parity
    logic [HALF_W-1:0] half_idx;
    logic [HALF_W-1:0] k2x1, k2x2, k2x3, row_base;
    logic [1:0]        row;
    tag_t              tag1_next, tag1_reg;
    logic [COL_W-1:0]  col_next, col_reg;

    // stage 2: prime multiply
    logic [PROD_W-1:0] prod_next, prod2_reg;
    tag_t              tag2_reg;

    // stage 3: quotient estimate
    logic [RECIP_W+PROD_W-1:0] qfull;
    logic [Q_W-1:0]            q_next, q_reg;
    logic [PROD_W-1:0]         prod3_reg;
    tag_t                      tag3_reg;

    // stage 4: raw remainder
    logic [PROD_W-1:0] qk2;
    logic [PROD_W-1:0] rem_full;
    logic [REM_W-1:0]  rem_next, rem_reg;
    tag_t              tag4_reg;

    // stage 5: corrected remainder and final address
    logic [REM_W-1:0] rem_fix;
    logic [COL_W-1:0] c_val;
    pos_t             perm_next, perm_reg;
    logic             oor_reg;

    assign k2    = k2_of(size_select_reg);
    assign recip = recip_of(size_select_reg);

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        half_idx = position[POS_W-1:1];
        k2x1     = HALF_W'(k2);
        k2x2     = HALF_W'({k2, 1'b0});
        k2x3     = k2x2 + k2x1;
        if (half_idx >= k2x3)
        begin
            row = 2'd3;
        end
        else if (half_idx >= k2x2)
        begin
            row = 2'd2;
        end
        else if (half_idx >= k2x1)
        begin
            row = 2'd1;
        end
        else
        begin
            row = 2'd0;
        end
        case (row)
            2'd0:    row_base = '0;
            2'd1:    row_base = k2x1;
            2'd2:    row_base = k2x2;
            2'd3:    row_base = k2x3;
            default: row_base = '0;
        endcase
        col_next      = COL_W'(half_idx - row_base);
        tag1_next.t   = t_of_row(row);
        tag1_next.m   = position[0];
        tag1_next.oor = (position >= POS_W'({k2, 3'b000}));
    end

    assign prod_next = PROD_W'(prime_of(tag1_reg.t)) * PROD_W'(col_reg)
                     + (tag1_reg.m ? PARITY_OFFSET : '0);

    assign qfull  = prod2_reg * recip;
    assign q_next = qfull[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];

    // estimate is exact or one low, so the remainder stays below 2*k2
    assign qk2      = PROD_W'(q_reg) * PROD_W'(k2);
    assign rem_full = prod3_reg - qk2;
    assign rem_next = rem_full[REM_W-1:0];

    always_comb
    begin
        rem_fix = (rem_reg >= REM_W'(k2)) ? (rem_reg - REM_W'(k2)) : rem_reg;
        c_val   = rem_fix[COL_W-1:0];
        // 8*c + 2*t + 1 - m packs as {c, t, ~m}
        if (tag4_reg.oor)
        begin
            perm_next = '0;
        end
        else
        begin
            perm_next = {c_val, tag4_reg.t, ~tag4_reg.m};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_select_reg <= SIZE_1784;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_select_reg <= cfg_wdata;
            end
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            col_reg  <= col_next;
            tag1_reg <= tag1_next;
        end
        if (rdy2 && v1_reg)
        begin
            prod2_reg <= prod_next;
            tag2_reg  <= tag1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            q_reg     <= q_next;
            prod3_reg <= prod2_reg;
            tag3_reg  <= tag2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            rem_reg  <= rem_next;
            tag4_reg <= tag3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            perm_reg <= perm_next;
            oor_reg  <= tag4_reg.oor;
        end
    end

    assign out_valid         = v5_reg;
    assign permuted_position = perm_reg;
    assign out_of_range      = oor_reg;

endmodule

// ----- design/ccsds_ti_checker.sv -----
// ----------------------------------------------------------------------------
// CCSDS turbo interleaver address - port checker
// Watches the top-level ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
`include "ccsds_turbo_interleaver_address_defines.svh"

module ccsds_ti_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input ccsds_ti_pkg::pos_t permuted_position,
    input logic               out_of_range
);
    import ccsds_ti_pkg::*;

    // hold a stalled result
    `CTI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(permuted_position) && $stable(out_of_range))

    // drop the address to zero on an out-of-range request
    `CTI_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_of_range, permuted_position == '0)

    `CTI_ASSERT_NOW(a_addr_bound, clk, rst_n, out_valid && !out_of_range, permuted_position < FRAME_LEN_MAX)

    // the pipeline only backs up when the output is stalled
    `CTI_ASSERT_NOW(a_backpressure, clk, rst_n, in_valid && !in_ready, out_valid && !out_ready)

endmodule

bind ccsds_turbo_interleaver_address ccsds_ti_checker u_ccsds_ti_checker (.*);

// ----- tb/ccsds_turbo_interleaver_address_tb.sv -----
// ----------------------------------------------------------------------------
// CCSDS turbo interleaver address - testbench
// Drives frame positions through the address generator under every frame
// size. A scoreboard works out each interleaved address and checks the
// returned ones in order. Both sides idle in random bursts, except in the
// last phase.
// ----------------------------------------------------------------------------
module ccsds_turbo_interleaver_address_tb;

    import ccsds_ti_pkg::*;

    localparam int LATENCY     = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;

    typedef struct {
        pos_t src;
        pos_t addr;
        logic oor;
    } address_entry_t;

    class interleave_checker;
        address_entry_t pending_addresses[$];
        int             mismatches = 0;

        task report_mismatch(input string msg);
            if (mismatches < 100)
                $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // compute the interleaved address for one position and hold it
        function void note_position(input pos_t pos, input size_t sel);
            address_entry_t e;
            int unsigned    k2;
            int unsigned    idx;
            int unsigned    m;
            int unsigned    row;
            int unsigned    col;
            int unsigned    t;
            int unsigned    p;
            int unsigned    c;
            case (sel)
                SIZE_1784: k2 = 223;
                SIZE_3568: k2 = 446;
                SIZE_7136: k2 = 892;
                default:   k2 = 1115;
            endcase
            idx   = pos;
            e.src = pos;
            if (idx >= 8 * k2) begin
                e.addr = '0;
                e.oor  = 1'b1;
            end
            else begin
                m   = idx % 2;
                row = idx / (2 * k2);
                col = idx / 2 - row * k2;
                t   = (19 * row + 1) % 4;
                case (t)
                    0:       p = 31;
                    1:       p = 37;
                    2:       p = 43;
                    default: p = 47;
                endcase
                c      = (p * col + 21 * m) % k2;
                e.addr = pos_t'(2 * (t + c * 4 + 1) - m - 1);
                e.oor  = 1'b0;
            end
            pending_addresses.push_back(e);
        endfunction

        task check_address(input pos_t addr, input logic oor);
            address_entry_t e;
            if (pending_addresses.size() == 0) begin
                report_mismatch($sformatf("unexpected result addr=%0d oor=%0b", addr, oor));
            end
            else begin
                e = pending_addresses.pop_front();
                if (addr !== e.addr)
                    report_mismatch($sformatf("pos %0d: addr %0d, want %0d",
                                              e.src, addr, e.addr));
                if (oor !== e.oor)
                    report_mismatch($sformatf("pos %0d: out_of_range %0b, want %0b",
                                              e.src, oor, e.oor));
            end
        endtask

        function int pending();
            return pending_addresses.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    size_t cfg_wdata;
    logic  in_valid;
    logic  in_ready;
    pos_t  position;
    logic  out_valid;
    logic  out_ready;
    pos_t  permuted_position;
    logic  out_of_range;

    interleave_checker sb;
    size_t             cur_size;
    bit                idle_on;
    bit                stall_on;
    int                cycles;

    ccsds_turbo_interleaver_address u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .position          (position),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .permuted_position (permuted_position),
        .out_of_range      (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // sample both handshakes on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_position(position, cur_size);
            if (out_valid && out_ready)
                sb.check_address(permuted_position, out_of_range);
        end
    end

    // receiver: stall in random bursts while enabled
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task send_position(input pos_t pos);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        // hold the request until it is taken
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and wait until every pending address has come back
    task drain_requests;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task write_size(input size_t sel);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sel;
        cur_size   = sel;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int frame_len(input size_t sel);
        case (sel)
            SIZE_1784: return 1784;
            SIZE_3568: return 3568;
            SIZE_7136: return 7136;
            default:   return 8920;
        endcase
    endfunction

    function automatic pos_t random_position(input size_t sel);
        int len;
        int r;
        len = frame_len(sel);
        r   = $urandom_range(0, 9);
        if (r == 0)
            return pos_t'($urandom_range(0, 16383));
        else if (r == 1)
            return pos_t'(len - 4 + $urandom_range(0, 7));
        else
            return pos_t'($urandom_range(0, len - 1));
    endfunction

    initial
    begin
        pos_t  small_dir[$];
        pos_t  big_dir[$];
        size_t sel;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = SIZE_1784;
        in_valid  = 1'b0;
        position  = '0;
        cur_size  = SIZE_1784;
        idle_on   = 1'b1;
        stall_on  = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset size: row and frame edges, all-ones and alternating bits
        small_dir = '{14'd0, 14'd1, 14'd445, 14'd446, 14'd447, 14'd1782, 14'd1783,
                      14'd1784, 14'd1785, 14'd16383, 14'h2AAA, 14'h1555};
        foreach (small_dir[i])
            send_position(small_dir[i]);
        drain_requests();

        write_size(SIZE_8920);
        big_dir = '{14'd0, 14'd1, 14'd2229, 14'd2230, 14'd8918, 14'd8919,
                    14'd8920, 14'd16383};
        foreach (big_dir[i])
            send_position(big_dir[i]);
        drain_requests();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       sel = SIZE_3568;
                1:       sel = SIZE_7136;
                2:       sel = SIZE_1784;
                3:       sel = SIZE_8920;
                default: sel = size_t'($urandom_range(0, 3));
            endcase
            if (ph == PHASES - 1)
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            write_size(sel);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain_requests();
                send_position(random_position(sel));
            end
            drain_requests();
        end

        if (sb.pending() != 0)
            sb.report_mismatch("addresses still pending at end of run");
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- ccsds_turbo_interleaver_address.f -----
+incdir+design
design/ccsds_ti_pkg.sv
design/ccsds_turbo_interleaver_address.sv
design/ccsds_ti_checker.sv
tb/ccsds_turbo_interleaver_address_tb.sv
